/* rtl/core/crt_pkg.sv */
// shared constants, codes and control types for the crt solver
`timescale 1ns / 1ps
package crt_pkg;

  localparam int MAX_MODULI = 4;
  localparam int MOD_WIDTH  = 16;
  localparam int IN_W       = 16;
  localparam int SOL_W      = 64;
  localparam int STAT_W     = 2;
  localparam int CNT_W      = $clog2(MAX_MODULI + 1);
  localparam int IDX_W      = (MAX_MODULI > 1) ? $clog2(MAX_MODULI) : 1;
  localparam int DVD_W      = 2 * MOD_WIDTH;
  localparam int T_W        = MOD_WIDTH + 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOINV = 2'd1,
    ST_BAD   = 2'd2
  } crt_status_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_CHECK,
    S_N_CHK,
    S_N_WAIT,
    S_K_CHK,
    S_Q_CHK,
    S_Q_WAIT,
    S_EU_INIT,
    S_EU_CHK,
    S_EU_WAIT,
    S_INV,
    S_RES_DIV,
    S_RES_WAIT,
    S_T_WAIT,
    S_X_UPD,
    S_OUT_OK,
    S_OUT_NOINV,
    S_OUT_BAD
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_STORE,
    OP_N_INIT,
    OP_N_MUL,
    OP_N_TAKE,
    OP_K_INIT,
    OP_J_SKIP,
    OP_Q_MUL,
    OP_Q_TAKE,
    OP_EU_INIT,
    OP_EU_DIV,
    OP_EU_UPD,
    OP_INV,
    OP_RES_DIV,
    OP_T_MUL,
    OP_X_DIFF,
    OP_X_UPD,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    crt_status_t status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad;
    logic j_end;
    logic j_is_k;
    logic k_end;
    logic mul_busy;
    logic div_busy;
    logic cur_zero;
    logic prev_one;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/core/crt_solver_top.sv */
// top level of the crt solver: controller plus datapath
// loading: one pair per cycle; the last pair starts the solve, input stalls meanwhile
// solve: one multiply per modulus for the product, then per pair a multiply and a divide
// per other modulus, a divide per euclid step, the inverse, a divide and a multiply for the term, then the update
// solve time is set by the bit-serial divider and the shift-add multiplier
// reset: synchronous active-low rst_n clears pair count, bad flag, controller and valid
`timescale 1ns / 1ps
module crt_solver_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [crt_pkg::IN_W-1:0]    in_residue,
  input  logic [crt_pkg::IN_W-1:0]    in_modulus,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [crt_pkg::SOL_W-1:0]   out_solution,
  output logic [crt_pkg::STAT_W-1:0]  out_status
);
  import crt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  crt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_residue   (in_residue),
    .in_modulus   (in_modulus),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_solution (out_solution),
    .out_status   (out_status)
  );

endmodule

/* rtl/core/crt_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module crt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [crt_pkg::DVD_W-1:0]     dividend,
  input  logic [crt_pkg::MOD_WIDTH-1:0] divisor,
  output logic                          busy,
  output logic [crt_pkg::DVD_W-1:0]     quotient,
  output logic [crt_pkg::MOD_WIDTH-1:0] remainder
);
  import crt_pkg::*;

  localparam int DC_W = $clog2(DVD_W + 1);

  logic [DC_W-1:0]      cnt_r;
  logic [DVD_W-1:0]     quo_r;
  logic [MOD_WIDTH-1:0] rem_r;
  logic [MOD_WIDTH-1:0] dvs_r;
  logic [MOD_WIDTH:0]   trial;
  logic                 ge;

  // trial subtract of the next bit
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    ge    = (trial >= {1'b0, dvs_r});
  end

  // bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DC_W'(DVD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // partial remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? MOD_WIDTH'(trial - {1'b0, dvs_r}) : trial[MOD_WIDTH-1:0];
    end
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/core/crt_dp.sv */
// datapath: pair store, shift-add multiplier, euclid registers, accumulator
`timescale 1ns / 1ps
module crt_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  crt_pkg::ctrl_cmd_t       cmd,
  output crt_pkg::dp_stat_t        stat,
  input  logic [crt_pkg::IN_W-1:0] in_residue,
  input  logic [crt_pkg::IN_W-1:0] in_modulus,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [crt_pkg::SOL_W-1:0] out_solution,
  output logic [crt_pkg::STAT_W-1:0] out_status
);
  import crt_pkg::*;

  logic [MOD_WIDTH-1:0] res_mem [MAX_MODULI];
  logic [MOD_WIDTH-1:0] mod_mem [MAX_MODULI];
  logic [CNT_W-1:0]     cnt_r;
  logic                 bad_r;
  logic [CNT_W-1:0]     k_r;
  logic [CNT_W-1:0]     j_r;
  logic [SOL_W-1:0]     n_r;
  logic [SOL_W-1:0]     q_r;
  logic [SOL_W-1:0]     x_r;
  logic [SOL_W-1:0]     d_r;
  logic [MOD_WIDTH-1:0] qm_r;
  logic [MOD_WIDTH-1:0] m_k_r;
  logic [MOD_WIDTH-1:0] res_k_r;
  logic [MOD_WIDTH-1:0] prev_r_r;
  logic [MOD_WIDTH-1:0] cur_r_r;
  logic signed [T_W-1:0] prev_t_r;
  logic signed [T_W-1:0] cur_t_r;
  logic [MOD_WIDTH-1:0] inv_r;
  logic [SOL_W-1:0]     mul_a_r;
  logic [MOD_WIDTH-1:0] mul_b_r;
  logic [SOL_W-1:0]     mul_p_r;
  logic                 out_valid_r;
  logic [SOL_W-1:0]     out_solution_r;
  logic [STAT_W-1:0]    out_status_r;

  logic [MOD_WIDTH-1:0] res_in;
  logic [MOD_WIDTH-1:0] mod_in;
  logic [IDX_W-1:0]     rd_idx;
  logic [MOD_WIDTH-1:0] mod_rd;
  logic                 mul_start;
  logic [SOL_W-1:0]     mul_a_in;
  logic [MOD_WIDTH-1:0] mul_b_in;
  logic                 mul_busy;
  logic                 div_start;
  logic [DVD_W-1:0]     div_dvd;
  logic [MOD_WIDTH-1:0] div_dvs;
  logic                 div_busy;
  logic [DVD_W-1:0]     div_quo;
  logic [MOD_WIDTH-1:0] div_rem;
  logic signed [T_W+MOD_WIDTH:0] qt_prod;
  logic signed [T_W-1:0] next_t;
  logic signed [T_W-1:0] inv_fix;

  // field masking and single read port into the pair store
  assign res_in = in_residue[MOD_WIDTH-1:0];
  assign mod_in = in_modulus[MOD_WIDTH-1:0];
  assign rd_idx = (cmd.op == OP_K_INIT) ? k_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign mod_rd = mod_mem[rd_idx];

  // pair store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE && mod_in != '0 && cnt_r < CNT_W'(MAX_MODULI)) begin
      res_mem[cnt_r[IDX_W-1:0]] <= res_in;
      mod_mem[cnt_r[IDX_W-1:0]] <= mod_in;
    end
  end

  // pair count and bad input flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      bad_r <= 1'b0;
    end else if (cmd.op == OP_STORE) begin
      if (mod_in == '0 || cnt_r >= CNT_W'(MAX_MODULI)) begin
        bad_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (cmd.op == OP_OUT) begin
      cnt_r <= '0;
      bad_r <= 1'b0;
    end
  end

  // loop indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      j_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_N_INIT: begin
          k_r <= '0;
          j_r <= '0;
        end
        OP_K_INIT:                   j_r <= '0;
        OP_N_MUL, OP_J_SKIP, OP_Q_MUL: j_r <= j_r + 1'b1;
        OP_X_UPD:                    k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

  // multiplier and divider operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a_in  = q_r;
    mul_b_in  = mod_rd;
    div_start = 1'b0;
    div_dvd   = DVD_W'(qm_r) * DVD_W'(mod_rd);
    div_dvs   = m_k_r;
    case (cmd.op)
      OP_N_MUL: begin
        mul_start = 1'b1;
        mul_a_in  = n_r;
      end
      OP_Q_MUL: begin
        mul_start = 1'b1;
        div_start = 1'b1;
      end
      OP_EU_DIV: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prev_r_r);
        div_dvs   = cur_r_r;
      end
      OP_RES_DIV: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(res_k_r) * DVD_W'(inv_r);
      end
      OP_T_MUL: begin
        mul_start = 1'b1;
        mul_b_in  = div_rem;
      end
      default: ;
    endcase
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_b_r <= '0;
    end else if (mul_start) begin
      mul_b_r <= mul_b_in;
    end else if (mul_busy) begin
      mul_b_r <= mul_b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_a_r <= mul_a_in;
      mul_p_r <= '0;
    end else if (mul_busy) begin
      if (mul_b_r[0]) begin
        mul_p_r <= mul_p_r + mul_a_r;
      end
      mul_a_r <= mul_a_r << 1;
    end
  end

  assign mul_busy = (mul_b_r != '0);

  crt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // euclid coefficient update and inverse fix-up
  always_comb begin
    qt_prod = $signed({1'b0, div_quo[MOD_WIDTH-1:0]}) * cur_t_r;
    next_t  = prev_t_r - qt_prod[T_W-1:0];
    inv_fix = prev_t_r[T_W-1] ? (prev_t_r + $signed(T_W'(m_k_r))) : prev_t_r;
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_N_INIT: begin
        n_r <= SOL_W'(1);
        x_r <= '0;
      end
      OP_N_TAKE: n_r <= mul_p_r;
      OP_K_INIT: begin
        q_r     <= SOL_W'(1);
        qm_r    <= MOD_WIDTH'(1);
        m_k_r   <= mod_rd;
        res_k_r <= res_mem[rd_idx];
      end
      OP_Q_TAKE: begin
        q_r  <= mul_p_r;
        qm_r <= div_rem;
      end
      OP_EU_INIT: begin
        prev_r_r <= m_k_r;
        cur_r_r  <= qm_r;
        prev_t_r <= '0;
        cur_t_r  <= T_W'(1);
      end
      OP_EU_UPD: begin
        prev_r_r <= cur_r_r;
        cur_r_r  <= div_rem;
        prev_t_r <= cur_t_r;
        cur_t_r  <= next_t;
      end
      OP_INV: inv_r <= (m_k_r == MOD_WIDTH'(1)) ? '0 : inv_fix[MOD_WIDTH-1:0];
      OP_X_DIFF: d_r <= n_r - mul_p_r;
      OP_X_UPD: x_r <= (x_r >= d_r) ? (x_r - d_r) : (x_r + mul_p_r);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_solution_r <= (cmd.status == ST_OK) ? x_r : '0;
      out_status_r   <= cmd.status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_solution = out_solution_r;
  assign out_status   = out_status_r;

  // status towards the controller
  always_comb begin
    stat.bad      = bad_r;
    stat.j_end    = (j_r == cnt_r);
    stat.j_is_k   = (j_r == k_r);
    stat.k_end    = (k_r == cnt_r);
    stat.mul_busy = mul_busy;
    stat.div_busy = div_busy;
    stat.cur_zero = (cur_r_r == '0);
    stat.prev_one = (prev_r_r == MOD_WIDTH'(1));
    stat.out_busy = out_valid_r && out_stall;
  end

endmodule

/* rtl/core/crt_ctrl.sv */
// controller: sequences loading, product, per-pair inverse and accumulation
`timescale 1ns / 1ps
module crt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_stall,
  input  crt_pkg::dp_stat_t     stat,
  output crt_pkg::ctrl_cmd_t    cmd
);
  import crt_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        units_idle;

  assign units_idle = !stat.mul_busy && !stat.div_busy;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:      if (in_valid && in_last) state_nxt = S_CHECK;
      S_CHECK:     state_nxt = stat.bad ? S_OUT_BAD : S_N_CHK;
      S_N_CHK:     state_nxt = stat.j_end ? S_K_CHK : S_N_WAIT;
      S_N_WAIT:    if (units_idle) state_nxt = S_N_CHK;
      S_K_CHK:     state_nxt = stat.k_end ? S_OUT_OK : S_Q_CHK;
      S_Q_CHK: begin
        if (stat.j_end) begin
          state_nxt = S_EU_INIT;
        end else if (!stat.j_is_k) begin
          state_nxt = S_Q_WAIT;
        end
      end
      S_Q_WAIT:    if (units_idle) state_nxt = S_Q_CHK;
      S_EU_INIT:   state_nxt = S_EU_CHK;
      S_EU_CHK: begin
        if (!stat.cur_zero) begin
          state_nxt = S_EU_WAIT;
        end else begin
          state_nxt = stat.prev_one ? S_INV : S_OUT_NOINV;
        end
      end
      S_EU_WAIT:   if (units_idle) state_nxt = S_EU_CHK;
      S_INV:       state_nxt = S_RES_DIV;
      S_RES_DIV:   state_nxt = S_RES_WAIT;
      S_RES_WAIT:  if (units_idle) state_nxt = S_T_WAIT;
      S_T_WAIT:    if (units_idle) state_nxt = S_X_UPD;
      S_X_UPD:     state_nxt = S_K_CHK;
      S_OUT_OK, S_OUT_NOINV, S_OUT_BAD: begin
        if (!stat.out_busy) state_nxt = S_LOAD;
      end
      default:     state_nxt = S_LOAD;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd.op     = OP_IDLE;
    cmd.status = ST_OK;
    in_stall   = 1'b1;
    unique case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_STORE;
      end
      S_CHECK:     if (!stat.bad) cmd.op = OP_N_INIT;
      S_N_CHK:     if (!stat.j_end) cmd.op = OP_N_MUL;
      S_N_WAIT:    if (units_idle) cmd.op = OP_N_TAKE;
      S_K_CHK:     if (!stat.k_end) cmd.op = OP_K_INIT;
      S_Q_CHK: begin
        if (!stat.j_end) cmd.op = stat.j_is_k ? OP_J_SKIP : OP_Q_MUL;
      end
      S_Q_WAIT:    if (units_idle) cmd.op = OP_Q_TAKE;
      S_EU_INIT:   cmd.op = OP_EU_INIT;
      S_EU_CHK:    if (!stat.cur_zero) cmd.op = OP_EU_DIV;
      S_EU_WAIT:   if (units_idle) cmd.op = OP_EU_UPD;
      S_INV:       cmd.op = OP_INV;
      S_RES_DIV:   cmd.op = OP_RES_DIV;
      S_RES_WAIT:  if (units_idle) cmd.op = OP_T_MUL;
      S_T_WAIT:    if (units_idle) cmd.op = OP_X_DIFF;
      S_X_UPD:     cmd.op = OP_X_UPD;
      S_OUT_OK:    if (!stat.out_busy) cmd.op = OP_OUT;
      S_OUT_NOINV: begin
        cmd.status = ST_NOINV;
        if (!stat.out_busy) cmd.op = OP_OUT;
      end
      S_OUT_BAD: begin
        cmd.status = ST_BAD;
        if (!stat.out_busy) cmd.op = OP_OUT;
      end
      default: ;
    endcase
  end

endmodule
